// ----- sv/spct_pkg.sv -----
// Shared definitions for the sorted position/color table: field widths,
// stream packing offsets, operation and status codes, and the cell control word.
// No dependencies.
`timescale 1ns / 1ps

package spct_pkg;

    // Default sizing of the table, handed to the top level parameters.
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_POS_BITS    = 16;
    localparam int DEF_COLOR_BITS  = 5;

    // Field widths as they appear on the stream ports.
    localparam int MODE_W        = 2;
    localparam int POS_FIELD_W   = 16;
    localparam int COLOR_FIELD_W = 5;
    localparam int SLOT_W        = 7;
    localparam int STATUS_W      = 2;

    // Input word packing, lowest field first.
    localparam int IN_MODE_LSB  = 0;
    localparam int IN_POS_LSB   = IN_MODE_LSB + MODE_W;
    localparam int IN_COLOR_LSB = IN_POS_LSB + POS_FIELD_W;
    localparam int IN_SLOT_LSB  = IN_COLOR_LSB + COLOR_FIELD_W;
    localparam int IN_FIELDS_W  = IN_SLOT_LSB + SLOT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output word packing, lowest field first.
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_POS_LSB    = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_COLOR_LSB  = OUT_POS_LSB + POS_FIELD_W;
    localparam int OUT_COUNT_LSB  = OUT_COLOR_LSB + COLOR_FIELD_W;
    localparam int OUT_EXCESS_LSB = OUT_COUNT_LSB + SLOT_W;
    localparam int OUT_FIELDS_W   = OUT_EXCESS_LSB + SLOT_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_FIELDS_W;

    // Operation codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_TRUNC = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    // Status codes of a result word.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    // Control strobes broadcast from the sequencer to every cell.
    typedef struct packed {
        logic capture;  // latch compare flags against the incoming word
        logic insert;   // shift up behind the insertion point and write new entry
        logic replace;  // overwrite the color of the matching entry
    } cell_ctrl_t;

endpackage

// ----- sv/spct_cell.sv -----
// One table cell: holds a single (position, color) entry and its compare flags.
// Takes shift data from its lower neighbor. Depends on spct_pkg.
`timescale 1ns / 1ps

module spct_cell #(
    parameter int CELL_IDX   = 0,
    parameter int POS_BITS   = spct_pkg::DEF_POS_BITS,
    parameter int COLOR_BITS = spct_pkg::DEF_COLOR_BITS,
    parameter int CMP_W      = spct_pkg::SLOT_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spct_pkg::cell_ctrl_t   ctrl,
    input  logic [POS_BITS-1:0]    cmp_key,
    input  logic [CMP_W-1:0]       cmp_idx,
    input  logic [CMP_W-1:0]       count,
    input  logic [POS_BITS-1:0]    wr_key,
    input  logic [COLOR_BITS-1:0]  wr_color,
    input  logic                   prev_lt,
    input  logic [POS_BITS-1:0]    prev_pos,
    input  logic [COLOR_BITS-1:0]  prev_color,
    output logic                   lt,
    output logic                   eq,
    output logic [POS_BITS-1:0]    pos,
    output logic [COLOR_BITS-1:0]  color,
    output logic [POS_BITS-1:0]    rd_pos,
    output logic [COLOR_BITS-1:0]  rd_color
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(CELL_IDX);

    logic                  lt_reg;
    logic                  eq_reg;
    logic                  sel_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  valid;

    // The entry is live while its index lies below the count.
    assign valid = (MY_IDX < count);

    // Compare flags are taken when a word is accepted and held until the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            lt_reg  <= valid && (pos_reg < cmp_key);
            eq_reg  <= valid && (pos_reg == cmp_key);
            sel_reg <= (MY_IDX == cmp_idx);
        end
    end

    // Cells above the insertion point take their neighbor's entry; the cell at
    // the insertion point takes the new entry; a matching cell takes the new color.
    always_ff @(posedge clk)
    begin
        priority if (ctrl.insert && !prev_lt)
        begin
            pos_reg   <= prev_pos;
            color_reg <= prev_color;
        end
        else if (ctrl.insert && !lt_reg)
        begin
            pos_reg   <= wr_key;
            color_reg <= wr_color;
        end
        else if (ctrl.replace && eq_reg)
        begin
            color_reg <= wr_color;
        end
        else
        begin
            // No update for this cell; the entry holds.
            pos_reg   <= pos_reg;
            color_reg <= color_reg;
        end
    end

    assign lt       = lt_reg;
    assign eq       = eq_reg;
    assign pos      = pos_reg;
    assign color    = color_reg;
    assign rd_pos   = sel_reg ? pos_reg : '0;
    assign rd_color = sel_reg ? color_reg : '0;

endmodule

// ----- sv/spct_array.sv -----
// Row of table cells chained by their shift path, plus the OR trees that
// gather the match flag and the selected entry. Depends on spct_pkg, spct_cell.
`timescale 1ns / 1ps

module spct_array #(
    parameter int TABLE_DEPTH = spct_pkg::DEF_TABLE_DEPTH,
    parameter int POS_BITS    = spct_pkg::DEF_POS_BITS,
    parameter int COLOR_BITS  = spct_pkg::DEF_COLOR_BITS,
    parameter int CMP_W       = spct_pkg::SLOT_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spct_pkg::cell_ctrl_t   ctrl,
    input  logic [POS_BITS-1:0]    cmp_key,
    input  logic [CMP_W-1:0]       cmp_idx,
    input  logic [CMP_W-1:0]       count,
    input  logic [POS_BITS-1:0]    wr_key,
    input  logic [COLOR_BITS-1:0]  wr_color,
    output logic                   hit,
    output logic [POS_BITS-1:0]    rd_pos,
    output logic [COLOR_BITS-1:0]  rd_color
);

    logic [TABLE_DEPTH-1:0] cell_lt;
    logic [TABLE_DEPTH-1:0] cell_eq;
    logic [POS_BITS-1:0]    cell_pos      [TABLE_DEPTH];
    logic [COLOR_BITS-1:0]  cell_color    [TABLE_DEPTH];
    logic [POS_BITS-1:0]    cell_rd_pos   [TABLE_DEPTH];
    logic [COLOR_BITS-1:0]  cell_rd_color [TABLE_DEPTH];

    // The cell chain. Cell zero sees a neighbor that always compares less,
    // so it never shifts.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic                  prev_lt;
        logic [POS_BITS-1:0]   prev_pos;
        logic [COLOR_BITS-1:0] prev_color;

        if (i == 0)
        begin : g_first
            assign prev_lt    = 1'b1;
            assign prev_pos   = wr_key;
            assign prev_color = wr_color;
        end
        else
        begin : g_next
            assign prev_lt    = cell_lt[i-1];
            assign prev_pos   = cell_pos[i-1];
            assign prev_color = cell_color[i-1];
        end

        spct_cell #(
            .CELL_IDX   (i),
            .POS_BITS   (POS_BITS),
            .COLOR_BITS (COLOR_BITS),
            .CMP_W      (CMP_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cmp_key    (cmp_key),
            .cmp_idx    (cmp_idx),
            .count      (count),
            .wr_key     (wr_key),
            .wr_color   (wr_color),
            .prev_lt    (prev_lt),
            .prev_pos   (prev_pos),
            .prev_color (prev_color),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i]),
            .pos        (cell_pos[i]),
            .color      (cell_color[i]),
            .rd_pos     (cell_rd_pos[i]),
            .rd_color   (cell_rd_color[i])
        );
    end

    // At most one cell matches the key, and at most one is selected for read.
    assign hit = |cell_eq;

    for (genvar b = 0; b < POS_BITS; b++)
    begin : g_rd_pos
        logic [TABLE_DEPTH-1:0] column;
        for (genvar i = 0; i < TABLE_DEPTH; i++)
        begin : g_col
            assign column[i] = cell_rd_pos[i][b];
        end
        assign rd_pos[b] = |column;
    end

    for (genvar b = 0; b < COLOR_BITS; b++)
    begin : g_rd_color
        logic [TABLE_DEPTH-1:0] column;
        for (genvar i = 0; i < TABLE_DEPTH; i++)
        begin : g_col
            assign column[i] = cell_rd_color[i][b];
        end
        assign rd_color[b] = |column;
    end

endmodule

// ----- sv/sorted_position_color_table.sv -----
// Top level of the sorted position/color table: stream ports, operation
// sequencer, count register and result register. Depends on spct_pkg, spct_array.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one operation word: add or replace an entry, truncate
// the count, or read an entry. The master stream returns exactly one result word
// for each operation, in order, with a status code, the read entry, the count
// after the operation and, on truncate, how far the index lay beyond the count.
// Timing: when a word is accepted, every cell compares it against its own entry
// at that edge; then, in the evaluate state and once the output register is
// free, the cells shift or write in parallel while the result is registered.
// A new word is accepted only after that commit; the compare-then-commit pass
// through the cell row does not depend on the table depth.
// Reset clears the count, so the table starts empty; the entries themselves are
// not cleared and no clearing pass runs. The block is ready right after reset.
// When the receiver stalls, one result word waits in the output register and the
// next operation is still accepted and compared; it then holds in the cells
// until the output register frees, and the slave side stays not ready meanwhile.

module sorted_position_color_table #(
    parameter int TABLE_DEPTH = spct_pkg::DEF_TABLE_DEPTH,
    parameter int POS_BITS    = spct_pkg::DEF_POS_BITS,
    parameter int COLOR_BITS  = spct_pkg::DEF_COLOR_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: mode[2], char_pos[16], color_index[5], slot_index[7], zero pad.
    input  logic [spct_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: status[2], read_pos[16], read_color[5], entry_count[7],
    // cleared_excess[7], zero pad.
    output logic [spct_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > spct_pkg::SLOT_W) ? CNT_W : spct_pkg::SLOT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } state_t;

    // Input word fields.
    logic [spct_pkg::MODE_W-1:0]        in_mode;
    logic [spct_pkg::POS_FIELD_W-1:0]   in_pos;
    logic [spct_pkg::COLOR_FIELD_W-1:0] in_color;
    logic [spct_pkg::SLOT_W-1:0]        in_slot;

    state_t                             state_reg;
    state_t                             state_next;
    logic [spct_pkg::MODE_W-1:0]        op_mode_reg;
    logic [POS_BITS-1:0]                key_reg;
    logic [COLOR_BITS-1:0]              color_reg;
    logic [spct_pkg::SLOT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;

    logic                               m_valid_reg;
    logic [spct_pkg::STATUS_W-1:0]      out_status_reg;
    logic [spct_pkg::POS_FIELD_W-1:0]   out_pos_reg;
    logic [spct_pkg::COLOR_FIELD_W-1:0] out_color_reg;
    logic [spct_pkg::SLOT_W-1:0]        out_count_reg;
    logic [spct_pkg::SLOT_W-1:0]        out_excess_reg;

    logic                               accept;
    logic                               commit;
    logic                               full;
    logic                               hit;
    logic                               do_insert;
    logic                               do_replace;
    logic [CMP_W-1:0]                   idx_ext;
    logic [CMP_W-1:0]                   cnt_ext;
    logic [POS_BITS-1:0]                rd_pos;
    logic [COLOR_BITS-1:0]              rd_color;
    spct_pkg::status_t                  res_status;
    logic [spct_pkg::POS_FIELD_W-1:0]   res_pos;
    logic [spct_pkg::COLOR_FIELD_W-1:0] res_color;
    logic [spct_pkg::SLOT_W-1:0]        res_excess;
    spct_pkg::cell_ctrl_t               ctrl;

    assign in_mode  = s_axis_tdata[spct_pkg::IN_MODE_LSB +: spct_pkg::MODE_W];
    assign in_pos   = s_axis_tdata[spct_pkg::IN_POS_LSB +: spct_pkg::POS_FIELD_W];
    assign in_color = s_axis_tdata[spct_pkg::IN_COLOR_LSB +: spct_pkg::COLOR_FIELD_W];
    assign in_slot  = s_axis_tdata[spct_pkg::IN_SLOT_LSB +: spct_pkg::SLOT_W];

    // Handshake: one operation in flight; the commit waits for a free output slot.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (state_reg == ST_EVAL) && (!m_valid_reg || m_axis_tready);

    assign full    = (count_reg == CNT_W'(TABLE_DEPTH));
    assign idx_ext = CMP_W'(idx_reg);
    assign cnt_ext = CMP_W'(count_reg);

    // Cell row.
    assign ctrl.capture = accept;
    assign ctrl.insert  = commit && do_insert;
    assign ctrl.replace = commit && do_replace;

    spct_array #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .POS_BITS    (POS_BITS),
        .COLOR_BITS  (COLOR_BITS),
        .CMP_W       (CMP_W)
    ) u_array (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmp_key  (POS_BITS'(in_pos)),
        .cmp_idx  (CMP_W'(in_slot)),
        .count    (cnt_ext),
        .wr_key   (key_reg),
        .wr_color (color_reg),
        .hit      (hit),
        .rd_pos   (rd_pos),
        .rd_color (rd_color)
    );

    // Result and count update of the operation held in the cells.
    always_comb
    begin
        count_next = count_reg;
        res_status = spct_pkg::STATUS_OK;
        res_pos    = '0;
        res_color  = '0;
        res_excess = '0;
        do_insert  = 1'b0;
        do_replace = 1'b0;
        unique case (op_mode_reg)
            spct_pkg::MODE_ADD:
            begin
                if (hit)
                begin
                    do_replace = 1'b1;
                end
                else if (full)
                begin
                    res_status = spct_pkg::STATUS_FULL;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spct_pkg::MODE_TRUNC:
            begin
                if (idx_ext > cnt_ext)
                begin
                    res_excess = spct_pkg::SLOT_W'(idx_ext - cnt_ext);
                end
                else
                begin
                    count_next = CNT_W'(idx_ext);
                end
            end
            spct_pkg::MODE_READ:
            begin
                if (idx_ext < cnt_ext)
                begin
                    res_pos   = spct_pkg::POS_FIELD_W'(rd_pos);
                    res_color = spct_pkg::COLOR_FIELD_W'(rd_color);
                end
                else
                begin
                    res_status = spct_pkg::STATUS_RANGE;
                end
            end
            default:
            begin
                // Unused code: no change, all-zero status, entry and excess.
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Operation word held for the commit cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg <= in_mode;
            key_reg     <= POS_BITS'(in_pos);
            color_reg   <= COLOR_BITS'(in_color);
            idx_reg     <= in_slot;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_status_reg <= res_status;
            out_pos_reg    <= res_pos;
            out_color_reg  <= res_color;
            out_count_reg  <= spct_pkg::SLOT_W'(count_next);
            out_excess_reg <= res_excess;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{spct_pkg::OUT_PAD_W{1'b0}}, out_excess_reg, out_count_reg,
                            out_color_reg, out_pos_reg, out_status_reg};

endmodule

// ----- sv/spct_checker.sv -----
// Port-level checks on the sorted position/color table and the bind that
// attaches them to its top level. Depends on spct_pkg, sorted_position_color_table.
`timescale 1ns / 1ps

module spct_checker #(
    parameter int TABLE_DEPTH = spct_pkg::DEF_TABLE_DEPTH
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [spct_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [spct_pkg::STATUS_W-1:0]      status;
    logic [spct_pkg::POS_FIELD_W-1:0]   read_pos;
    logic [spct_pkg::COLOR_FIELD_W-1:0] read_color;
    logic [spct_pkg::SLOT_W-1:0]        entry_count;
    logic [spct_pkg::SLOT_W-1:0]        cleared_excess;

    assign status         = m_axis_tdata[spct_pkg::OUT_STATUS_LSB +: spct_pkg::STATUS_W];
    assign read_pos       = m_axis_tdata[spct_pkg::OUT_POS_LSB +: spct_pkg::POS_FIELD_W];
    assign read_color     = m_axis_tdata[spct_pkg::OUT_COLOR_LSB +: spct_pkg::COLOR_FIELD_W];
    assign entry_count    = m_axis_tdata[spct_pkg::OUT_COUNT_LSB +: spct_pkg::SLOT_W];
    assign cleared_excess = m_axis_tdata[spct_pkg::OUT_EXCESS_LSB +: spct_pkg::SLOT_W];

    // Only one operation is in flight: the slave side drops ready after an accept.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted while an operation was in flight");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // A dropped add only happens on a full table and returns no entry.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status == spct_pkg::STATUS_FULL) |->
        (entry_count == spct_pkg::SLOT_W'(TABLE_DEPTH)) && (read_pos == '0) &&
        (read_color == '0) && (cleared_excess == '0))
        else $error("full status with inconsistent fields");

    // A failed read returns a zero entry.
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status == spct_pkg::STATUS_RANGE) |->
        (read_pos == '0) && (read_color == '0) && (cleared_excess == '0))
        else $error("range status with nonzero entry");

    // A truncate beyond the count reports ok and leaves the read fields zero.
    a_excess_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (cleared_excess != '0) |->
        (status == spct_pkg::STATUS_OK) && (read_pos == '0) && (read_color == '0))
        else $error("excess reported with other fields set");

endmodule

bind sorted_position_color_table spct_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_spct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for sorted_position_color_table: directed table walk,
// then randomized scenarios checked against a behavioral table predictor.
// Depends on spct_pkg and the sorted_position_color_table RTL.
`timescale 1ns / 1ps

module tb_top;

    import spct_pkg::*;

    localparam int DEPTH         = DEF_TABLE_DEPTH;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DIRECTED_N    = 23;
    // The mode field has a fourth code that the block must leave without effect.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // One operation word, fields as on the slave stream.
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_FIELD_W-1:0]   pos;
        logic [COLOR_FIELD_W-1:0] color;
        logic [SLOT_W-1:0]        slot;
    } table_op_t;

    // One result word, fields as on the master stream.
    typedef struct packed {
        status_t                  status;
        logic [POS_FIELD_W-1:0]   rpos;
        logic [COLOR_FIELD_W-1:0] rcolor;
        logic [SLOT_W-1:0]        count;
        logic [SLOT_W-1:0]        excess;
    } table_result_t;

    // A directed row: the operation and, when fixed is set, its typed-in result.
    typedef struct packed {
        bit            fixed;
        table_op_t     op;
        table_result_t want;
    } directed_row_t;

    localparam table_result_t NO_WANT = '0;

    localparam directed_row_t DIRECTED [DIRECTED_N] = '{
        // Empty table right after reset.
        '{1'b1, '{MODE_READ,   16'h0000, 5'd0,  7'd0},
              '{STATUS_RANGE, 16'h0000, 5'd0,  7'd0, 7'd0}},
        '{1'b1, '{MODE_TRUNC,  16'h0000, 5'd0,  7'd5},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd0, 7'd5}},
        '{1'b1, '{MODE_UNUSED, 16'h0000, 5'd0,  7'd0},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd0, 7'd0}},
        // Inserts at both ends, in the middle, and a replace of an existing key.
        '{1'b1, '{MODE_ADD,    16'hFFFF, 5'd31, 7'd0},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd1, 7'd0}},
        '{1'b1, '{MODE_ADD,    16'h0000, 5'd0,  7'd0},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd2, 7'd0}},
        '{1'b1, '{MODE_ADD,    16'h8000, 5'd21, 7'd0},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd3, 7'd0}},
        '{1'b1, '{MODE_ADD,    16'h8000, 5'd10, 7'd0},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd3, 7'd0}},
        '{1'b0, '{MODE_ADD,    16'h1234, 5'd5,  7'd0},  NO_WANT},
        // Read back the whole table and just past its end.
        '{1'b1, '{MODE_READ,   16'h0000, 5'd0,  7'd0},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd4, 7'd0}},
        '{1'b0, '{MODE_READ,   16'h0000, 5'd0,  7'd1},  NO_WANT},
        '{1'b0, '{MODE_READ,   16'h0000, 5'd0,  7'd2},  NO_WANT},
        '{1'b1, '{MODE_READ,   16'h0000, 5'd0,  7'd3},
              '{STATUS_OK,    16'hFFFF, 5'd31, 7'd4, 7'd0}},
        '{1'b1, '{MODE_READ,   16'h0000, 5'd0,  7'd4},
              '{STATUS_RANGE, 16'h0000, 5'd0,  7'd4, 7'd0}},
        '{1'b1, '{MODE_READ,   16'h0000, 5'd0,  7'd64},
              '{STATUS_RANGE, 16'h0000, 5'd0,  7'd4, 7'd0}},
        // Truncate above, at and below the count.
        '{1'b1, '{MODE_TRUNC,  16'h0000, 5'd0,  7'd64},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd4, 7'd60}},
        '{1'b1, '{MODE_TRUNC,  16'h0000, 5'd0,  7'd4},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd4, 7'd0}},
        '{1'b0, '{MODE_TRUNC,  16'h0000, 5'd0,  7'd2},  NO_WANT},
        '{1'b0, '{MODE_READ,   16'h0000, 5'd0,  7'd2},  NO_WANT},
        '{1'b0, '{MODE_ADD,    16'h8000, 5'd31, 7'd0},  NO_WANT},
        '{1'b0, '{MODE_UNUSED, 16'hFFFF, 5'd31, 7'd64}, NO_WANT},
        '{1'b1, '{MODE_TRUNC,  16'h0000, 5'd0,  7'd0},
              '{STATUS_OK,    16'h0000, 5'd0,  7'd0, 7'd0}},
        '{1'b0, '{MODE_ADD,    16'h5555, 5'd21, 7'd0},  NO_WANT},
        '{1'b0, '{MODE_ADD,    16'hAAAA, 5'd10, 7'd0},  NO_WANT}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor copy of the table.
    logic [POS_FIELD_W-1:0]   model_pos   [DEPTH];
    logic [COLOR_FIELD_W-1:0] model_color [DEPTH];
    int                       model_count;

    // Counters start at zero as every int does.
    table_result_t expected_results [$];
    int            mismatch_count;
    int            burst_left;
    int            random_items;
    int            idle_cycles;
    int            rx_style;
    int            rx_left;
    int            rx_cycle;

    sorted_position_color_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one operation to the predictor table and return its result word.
    function automatic table_result_t predict_table_op(table_op_t op);
        table_result_t r;
        int            at;
        r  = '0;
        at = 0;
        case (op.mode)
            MODE_ADD:
            begin
                while (at < model_count && model_pos[at] < op.pos)
                    at++;
                if (at < model_count && model_pos[at] == op.pos)
                    model_color[at] = op.color;
                else if (model_count >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    for (int j = model_count; j > at; j--)
                    begin
                        model_pos[j]   = model_pos[j-1];
                        model_color[j] = model_color[j-1];
                    end
                    model_pos[at]   = op.pos;
                    model_color[at] = op.color;
                    model_count++;
                end
            end
            MODE_TRUNC:
            begin
                if (op.slot > model_count)
                    r.excess = SLOT_W'(int'(op.slot) - model_count);
                else
                    model_count = int'(op.slot);
            end
            MODE_READ:
            begin
                if (op.slot < model_count)
                begin
                    r.rpos   = model_pos[op.slot];
                    r.rcolor = model_color[op.slot];
                end
                else
                    r.status = STATUS_RANGE;
            end
            default:
            begin
            end
        endcase
        r.count = SLOT_W'(model_count);
        return r;
    endfunction

    // Random operation of a given mode, biased toward keys and indexes that matter.
    function automatic table_op_t random_op(logic [MODE_W-1:0] mode);
        table_op_t op;
        op.mode  = mode;
        op.pos   = POS_FIELD_W'($urandom_range(0, 65535));
        op.color = COLOR_FIELD_W'($urandom_range(0, 31));
        op.slot  = SLOT_W'($urandom_range(0, DEPTH));
        if ($urandom_range(0, 15) == 0)
            op.pos = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (mode == MODE_ADD && model_count != 0 && $urandom_range(0, 2) == 0)
            op.pos = model_pos[$urandom_range(0, model_count - 1)];
        if (mode == MODE_READ && $urandom_range(0, 3) != 0)
            op.slot = SLOT_W'($urandom_range(0, model_count));
        if (mode == MODE_TRUNC && $urandom_range(0, 1) == 0)
            op.slot = SLOT_W'((model_count > 3) ? model_count - int'($urandom_range(0, 3))
                                                : model_count);
        return op;
    endfunction

    // Send one word, honoring the burst/gap pattern, and record its expected result.
    task automatic send_op(input table_op_t op, input bit fixed = 1'b0,
                           input table_result_t want = '0);
        logic [IN_TDATA_W-1:0] word;
        table_result_t         predicted;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        word = '0;
        word[IN_MODE_LSB  +: MODE_W]        = op.mode;
        word[IN_POS_LSB   +: POS_FIELD_W]   = op.pos;
        word[IN_COLOR_LSB +: COLOR_FIELD_W] = op.color;
        word[IN_SLOT_LSB  +: SLOT_W]        = op.slot;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_table_op(op);
        expected_results.push_back(fixed ? want : predicted);
        if (op.mode != MODE_UNUSED)
            random_items++;
    endtask

    // Hold the sender off until every outstanding result has been returned.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        burst_left = $urandom_range(1, 16);
    endtask

    // Stimulus: reset, directed rows, then randomized scenarios.
    initial
    begin
        int pick;
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        burst_left     = 0;
        model_count    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_op(DIRECTED[i].op, DIRECTED[i].fixed, DIRECTED[i].want);
        wait_drain();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // Fill the table, then push past full with new and existing keys.
                table_op_t op;
                op      = random_op(MODE_TRUNC);
                op.slot = SLOT_W'($urandom_range(0, DEPTH));
                send_op(op);
                while (model_count < DEPTH)
                    send_op(random_op(MODE_ADD));
                repeat ($urandom_range(3, 8))
                    send_op(random_op(MODE_ADD));
                repeat ($urandom_range(2, 6))
                begin
                    op      = random_op(MODE_READ);
                    op.slot = SLOT_W'($urandom_range(DEPTH - 4, DEPTH));
                    send_op(op);
                end
            end
            else if (pick < 90)
            begin
                // Mixed traffic weighted toward adds and reads.
                repeat ($urandom_range(20, 60))
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        send_op(random_op(MODE_ADD));
                    else if (pick < 80)
                        send_op(random_op(MODE_READ));
                    else if (pick < 92)
                        send_op(random_op(MODE_TRUNC));
                    else
                        send_op(random_op(MODE_UNUSED));
                end
            end
            else
            begin
                // Noise: any mode with unbiased fields.
                table_op_t op;
                repeat ($urandom_range(5, 20))
                begin
                    op.mode  = MODE_W'($urandom_range(0, 3));
                    op.pos   = POS_FIELD_W'($urandom_range(0, 65535));
                    op.color = COLOR_FIELD_W'($urandom_range(0, 31));
                    op.slot  = SLOT_W'($urandom_range(0, DEPTH));
                    send_op(op);
                end
            end
            if ($urandom_range(0, 5) == 0)
                wait_drain();
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Receiver: phases of full readiness, random stalls and a fixed duty pattern.
    always @(posedge clk)
    begin
        if (rx_left <= 0)
        begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(20, 300);
        end
        rx_left--;
        rx_cycle++;
        case (rx_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((rx_cycle % 7) < 3);
        endcase
    end

    // Compare each returned word with the oldest expectation.
    always @(posedge clk)
    begin
        table_result_t want;
        table_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = status_t'(m_axis_tdata[OUT_STATUS_LSB +: STATUS_W]);
            got.rpos   = m_axis_tdata[OUT_POS_LSB    +: POS_FIELD_W];
            got.rcolor = m_axis_tdata[OUT_COLOR_LSB  +: COLOR_FIELD_W];
            got.count  = m_axis_tdata[OUT_COUNT_LSB  +: SLOT_W];
            got.excess = m_axis_tdata[OUT_EXCESS_LSB +: SLOT_W];
            if (expected_results.size() == 0)
            begin
                $error("result word with no operation outstanding: %0h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.rpos !== want.rpos)
                begin
                    $error("read_pos: expected %0h, got %0h", want.rpos, got.rpos);
                    mismatch_count++;
                end
                if (got.rcolor !== want.rcolor)
                begin
                    $error("read_color: expected %0d, got %0d", want.rcolor, got.rcolor);
                    mismatch_count++;
                end
                if (got.count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    mismatch_count++;
                end
                if (got.excess !== want.excess)
                begin
                    $error("cleared_excess: expected %0d, got %0d", want.excess, got.excess);
                    mismatch_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
                begin
                    $error("pad: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule
